// ===== rtl/zomt_pkg.sv =====
package zomt_pkg;

  localparam int unsigned KindW = 2;
  localparam int unsigned IdxW  = 6;
  localparam int unsigned ZoneW = 6;
  localparam int unsigned MaskW = 64;
  localparam int unsigned CntW  = 16;

  // Depth of the command queue between front and back, and of the result queue.
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned ResDepth = 4;

  // Codes of the kind field on the input port.
  localparam logic [KindW-1:0] KIND_REG   = 2'd0;
  localparam logic [KindW-1:0] KIND_UNREG = 2'd1;
  localparam logic [KindW-1:0] KIND_REL   = 2'd2;

  localparam logic [CntW-1:0] CNT_MAX = {CntW{1'b1}};

  typedef enum logic [1:0] {
    OP_REG   = 2'd0,
    OP_UNREG = 2'd1,
    OP_REL   = 2'd2
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IdxW-1:0]  idx;
    logic [ZoneW-1:0] zone;
    logic [MaskW-1:0] mask;
  } cmd_t;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic            last;
  } res_t;

endpackage

// ===== rtl/zomt_front.sv =====
module zomt_front
  import zomt_pkg::*;
#(
  parameter int unsigned STRING_SLOTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [KindW-1:0] kind_i,
  input  logic [IdxW-1:0]  string_index_i,
  input  logic [ZoneW-1:0] zone_index_i,
  input  logic [MaskW-1:0] zone_mask_i,
  output logic             cmd_valid_o,
  output cmd_t             cmd_o,
  input  logic             cmd_pop_i
);

  localparam int unsigned PtrW = $clog2(CmdDepth);
  localparam int unsigned CntQW = $clog2(CmdDepth + 1);

  cmd_t             q_mem [CmdDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntQW-1:0] cnt_q, cnt_d;

  cmd_t             cmd_new;
  logic             keep;
  logic             slot_ok;
  logic [MaskW-1:0] rel_mask;
  logic             do_wr;
  logic             do_rd;

  // Items that can have no effect on the table are taken and dropped here.
  assign slot_ok  = (string_index_i != '0) &&
                    ({1'b0, string_index_i} < (IdxW + 1)'(STRING_SLOTS));
  assign rel_mask = zone_mask_i & ~MaskW'(1);

  always_comb begin
    cmd_new.idx  = string_index_i;
    cmd_new.zone = zone_index_i;
    cmd_new.mask = rel_mask;
    cmd_new.op   = OP_REG;
    keep         = 1'b0;
    unique case (kind_i)
      KIND_REG: begin
        cmd_new.op = OP_REG;
        keep       = slot_ok;
      end
      KIND_UNREG: begin
        cmd_new.op = OP_UNREG;
        keep       = slot_ok;
      end
      KIND_REL: begin
        cmd_new.op = OP_REL;
        keep       = (rel_mask != '0);
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign full_o      = (cnt_q == CntQW'(CmdDepth));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = q_mem[rd_ptr_q];

  assign do_wr = push_i && !full_o && keep;
  assign do_rd = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntQW'(1);
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - CntQW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ===== rtl/zomt_rfifo.sv =====
module zomt_rfifo
  import zomt_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t res_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output res_t res_o
);

  localparam int unsigned PtrW = $clog2(ResDepth);
  localparam int unsigned CntQW = $clog2(ResDepth + 1);

  res_t             mem [ResDepth];
  logic [PtrW-1:0]  wr_ptr_q;
  logic [PtrW-1:0]  rd_ptr_q;
  logic [CntQW-1:0] cnt_q, cnt_d;
  logic             do_wr;
  logic             do_rd;

  assign full_o  = (cnt_q == CntQW'(ResDepth));
  assign empty_o = (cnt_q == '0);
  assign res_o   = mem[rd_ptr_q];

  assign do_wr = push_i && !full_o;
  assign do_rd = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntQW'(1);
    end else if (!do_wr && do_rd) begin
      cnt_d = cnt_q - CntQW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem[wr_ptr_q] <= res_i;
    end
  end

endmodule

// ===== rtl/zomt_back.sv =====
module zomt_back
  import zomt_pkg::*;
#(
  parameter int unsigned STRING_SLOTS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  localparam int unsigned AW = (STRING_SLOTS > 1) ? $clog2(STRING_SLOTS) : 1;
  localparam int unsigned PW = $clog2(STRING_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RMW   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;
  cmd_t   cur_q, cur_d;

  // Table storage; the valid bits make an entry that was never written read as zero.
  logic [MaskW-1:0]        mask_mem [STRING_SLOTS];
  logic [CntW-1:0]         cnt_mem  [STRING_SLOTS];
  logic [STRING_SLOTS-1:0] mvld_q;
  logic [STRING_SLOTS-1:0] cvld_q;

  logic             ren;
  logic [AW-1:0]    raddr;
  logic [MaskW-1:0] rd_mask_q;
  logic [CntW-1:0]  rd_cnt_q;
  logic             rd_mvld_q;
  logic             rd_cvld_q;

  logic             mask_we;
  logic             cnt_we;
  logic [AW-1:0]    waddr;
  logic [MaskW-1:0] wmask;
  logic [CntW-1:0]  wcnt;

  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [AW-1:0]    wp_q, wp_d;
  logic             pend_q, pend_d;
  logic [AW-1:0]    held_q, held_d;
  logic             held_v_q, held_v_d;

  logic [MaskW-1:0] old_mask;
  logic [CntW-1:0]  old_cnt;
  logic [CntW-1:0]  dec_cnt;
  logic [MaskW-1:0] unreg_mask;
  logic [MaskW-1:0] scan_mask;
  logic             scan_hit;

  assign old_mask   = rd_mvld_q ? rd_mask_q : '0;
  assign old_cnt    = rd_cvld_q ? rd_cnt_q : '0;
  assign dec_cnt    = old_cnt - CntW'(1);
  assign unreg_mask = (dec_cnt == '0) ? (old_mask & ~MaskW'(1)) : old_mask;
  assign scan_mask  = old_mask & ~cur_q.mask;
  assign scan_hit   = ((old_mask & cur_q.mask) != '0);

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    rd_ptr_d   = rd_ptr_q;
    wp_d       = wp_q;
    pend_d     = pend_q;
    held_d     = held_q;
    held_v_d   = held_v_q;
    cmd_pop_o  = 1'b0;
    ren        = 1'b0;
    raddr      = cur_q.idx[AW-1:0];
    mask_we    = 1'b0;
    cnt_we     = 1'b0;
    waddr      = cur_q.idx[AW-1:0];
    wmask      = old_mask;
    wcnt       = old_cnt;
    res_push_o = 1'b0;
    res_o.idx  = IdxW'(held_q);
    res_o.last = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cur_d     = cmd_i;
          if (cmd_i.op == OP_REL) begin
            state_d  = S_SCAN;
            rd_ptr_d = PW'(1);
            pend_d   = 1'b0;
            held_v_d = 1'b0;
          end else begin
            state_d = S_RMW;
            ren     = 1'b1;
            raddr   = cmd_i.idx[AW-1:0];
          end
        end
      end

      S_RMW: begin
        if (cur_q.op == OP_REG) begin
          mask_we = 1'b1;
          cnt_we  = 1'b1;
          wmask   = old_mask | (MaskW'(1) << cur_q.zone);
          if ((cur_q.zone == '0) && (old_cnt != CNT_MAX)) begin
            wcnt = old_cnt + CntW'(1);
          end
          state_d = S_IDLE;
        end else if (old_cnt == '0) begin
          state_d = S_IDLE;
        end else if (!((unreg_mask == '0) && res_full_i)) begin
          mask_we    = 1'b1;
          cnt_we     = 1'b1;
          wmask      = unreg_mask;
          wcnt       = dec_cnt;
          res_push_o = (unreg_mask == '0);
          res_o.idx  = cur_q.idx;
          res_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end

      S_SCAN: begin
        if (!res_full_i) begin
          if (pend_q) begin
            waddr   = wp_q;
            wmask   = scan_mask;
            mask_we = scan_hit;
            if (scan_hit && (scan_mask == '0)) begin
              res_push_o = held_v_q;
              held_d     = wp_q;
              held_v_d   = 1'b1;
            end
          end
          if (rd_ptr_q < PW'(STRING_SLOTS)) begin
            ren      = 1'b1;
            raddr    = rd_ptr_q[AW-1:0];
            wp_d     = rd_ptr_q[AW-1:0];
            pend_d   = 1'b1;
            rd_ptr_d = rd_ptr_q + PW'(1);
          end else begin
            pend_d  = 1'b0;
            state_d = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!held_v_q) begin
          state_d = S_IDLE;
        end else if (!res_full_i) begin
          res_push_o = 1'b1;
          res_o.last = 1'b1;
          held_v_d   = 1'b0;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      rd_ptr_q  <= '0;
      pend_q    <= 1'b0;
      held_v_q  <= 1'b0;
      mvld_q    <= '0;
      cvld_q    <= '0;
      rd_mvld_q <= 1'b0;
      rd_cvld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_ptr_q <= rd_ptr_d;
      pend_q   <= pend_d;
      held_v_q <= held_v_d;
      if (mask_we) begin
        mvld_q[waddr] <= 1'b1;
      end
      if (cnt_we) begin
        cvld_q[waddr] <= 1'b1;
      end
      if (ren) begin
        rd_mvld_q <= mvld_q[raddr];
        rd_cvld_q <= cvld_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    wp_q   <= wp_d;
    held_q <= held_d;
  end

  // Table memories: one write port and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (mask_we) begin
      mask_mem[waddr] <= wmask;
    end
    if (cnt_we) begin
      cnt_mem[waddr] <= wcnt;
    end
    if (ren) begin
      rd_mask_q <= mask_mem[raddr];
      rd_cnt_q  <= cnt_mem[raddr];
    end
  end

`ifndef ASSERT_OFF
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into a full result queue");

  a_flush_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> ((rd_ptr_q == PW'(STRING_SLOTS)) && !pend_q))
    else $error("flush entered before the scan finished");

  a_held_in_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_v_q |-> ((state_q == S_SCAN) || (state_q == S_FLUSH)))
    else $error("held release result outside a release scan");

  a_scan_skips_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SCAN) && pend_q) |-> (wp_q != '0))
    else $error("scan touched entry zero");
`endif

endmodule

// ===== rtl/zone_ownership_mask_table.sv =====
// Zone ownership mask table.
// Input beats arrive on a queue-style port: a beat is taken on a rising edge
// with push_i high and full_o low. Each beat registers a zone as owner of an
// entry, drops one zone-0 reference from an entry, or releases a zone mask
// from every entry. The front stage classifies beats, drops those that cannot
// change the table and holds up to two commands for the back stage.
// Result beats leave through a four-deep result queue: while empty_o is low the
// oldest result is on released_string_o and last_of_run_o, and it is taken on
// a rising edge with pop_i high. The final result of a release has
// last_of_run_o set, as does the single result of an unregister.
// Back stage: a register or unregister beat takes one table read, then one
// read-modify-write. A release beat walks entries 1 to STRING_SLOTS-1 through
// the single table read port, one entry a cycle while the result queue has
// room; the back stage takes the command, walks the table with its final
// write, then pushes the last result. It takes no new command until then.
// If the result queue fills, the back stage pauses and the command queue then
// fills, raising full_o; nothing is lost. Reset clears both queues and marks
// every table entry invalid, so all masks and counts read as zero at once.
module zone_ownership_mask_table
  import zomt_pkg::*;
#(
  parameter int unsigned STRING_SLOTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [KindW-1:0] kind_i,
  input  logic [IdxW-1:0]  string_index_i,
  input  logic [ZoneW-1:0] zone_index_i,
  input  logic [MaskW-1:0] zone_mask_i,
  output logic             empty_o,
  input  logic             pop_i,
  output logic [IdxW-1:0]  released_string_o,
  output logic             last_of_run_o
);

  // Command path between the classifying front and the table engine.
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  // Result path from the engine into the output queue.
  res_t res_in;
  res_t res_out;
  logic res_push;
  logic res_full;

  zomt_front #(
    .STRING_SLOTS(STRING_SLOTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .kind_i        (kind_i),
    .string_index_i(string_index_i),
    .zone_index_i  (zone_index_i),
    .zone_mask_i   (zone_mask_i),
    .cmd_valid_o   (cmd_valid),
    .cmd_o         (cmd),
    .cmd_pop_i     (cmd_pop)
  );

  zomt_back #(
    .STRING_SLOTS(STRING_SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(cmd_valid),
    .cmd_i      (cmd),
    .cmd_pop_o  (cmd_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  zomt_rfifo u_rfifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .res_i  (res_in),
    .full_o (res_full),
    .pop_i  (pop_i),
    .empty_o(empty_o),
    .res_o  (res_out)
  );

  assign released_string_o = res_out.idx;
  assign last_of_run_o     = res_out.last;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import zomt_pkg::*;

  localparam int unsigned SLOTS = 64;

  // Kind code that the block must ignore; the package names only the three live ones.
  localparam logic [KindW-1:0] KIND_SPARE = 2'd3;

  // One input beat, held as the fields that go onto the ports.
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [IdxW-1:0]  idx;
    logic [ZoneW-1:0] zone;
    logic [MaskW-1:0] mask;
  } zone_beat_t;

  // Shadow of the ownership table. Every accepted input beat is applied to the
  // shadow copy, and any entry that it empties is queued as an expected release
  // in the order that the block must deliver it. Result beats are then checked
  // against the head of that queue.
  class ownership_ledger #(int unsigned SLOTS = 64);
    logic [MaskW-1:0] owners [SLOTS];
    logic [CntW-1:0]  zone0_refs [SLOTS];
    res_t             pending_releases [$];
    int unsigned      faults;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        owners[i]     = '0;
        zone0_refs[i] = '0;
      end
      faults = 0;
    endfunction

    function bit slot_live(logic [IdxW-1:0] idx);
      return idx != '0 && int'(idx) < SLOTS;
    endfunction

    function int unsigned pending();
      return pending_releases.size();
    endfunction

    function void note_beat(zone_beat_t b);
      logic [MaskW-1:0] m;
      logic [SLOTS-1:0] emptied;
      int unsigned      tail;
      res_t             r;
      case (b.kind)
        KIND_REG: begin
          if (!slot_live(b.idx)) return;
          if (b.zone == '0 && zone0_refs[b.idx] != CNT_MAX) zone0_refs[b.idx]++;
          owners[b.idx][b.zone] = 1'b1;
        end
        KIND_UNREG: begin
          if (!slot_live(b.idx) || zone0_refs[b.idx] == '0) return;
          zone0_refs[b.idx]--;
          if (zone0_refs[b.idx] == '0) owners[b.idx][0] = 1'b0;
          if (owners[b.idx] == '0) begin
            r.idx  = b.idx;
            r.last = 1'b1;
            pending_releases.push_back(r);
          end
        end
        KIND_REL: begin
          // Zone 0 is never released by mask; its bit follows the reference count.
          m    = b.mask;
          m[0] = 1'b0;
          if (m == '0) return;
          emptied = '0;
          tail    = 0;
          for (int unsigned i = 1; i < SLOTS; i++) begin
            if ((owners[i] & m) != '0) begin
              owners[i] = owners[i] & ~m;
              if (owners[i] == '0) begin
                emptied[i] = 1'b1;
                tail       = i;
              end
            end
          end
          for (int unsigned i = 1; i < SLOTS; i++) begin
            if (emptied[i]) begin
              r.idx  = IdxW'(i);
              r.last = (i == tail);
              pending_releases.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      faults++;
    endtask

    task check_release(logic [IdxW-1:0] idx, logic last);
      res_t want;
      if (pending_releases.size() == 0) begin
        report_mismatch($sformatf("entry %0d released with nothing outstanding", idx));
        return;
      end
      want = pending_releases.pop_front();
      if (idx !== want.idx)
        report_mismatch($sformatf("released_string %0d, expected %0d", idx, want.idx));
      if (last !== want.last)
        report_mismatch($sformatf("last_of_run %b on entry %0d, expected %b",
                                  last, want.idx, want.last));
    endtask
  endclass

  logic             clk_i             = 1'b0;
  logic             rst_ni            = 1'b0;
  logic             push_i            = 1'b0;
  logic [KindW-1:0] kind_i            = '0;
  logic [IdxW-1:0]  string_index_i    = '0;
  logic [ZoneW-1:0] zone_index_i      = '0;
  logic [MaskW-1:0] zone_mask_i       = '0;
  logic             pop_i             = 1'b0;
  logic             full_o;
  logic             empty_o;
  logic [IdxW-1:0]  released_string_o;
  logic             last_of_run_o;

  // Percentages of cycles in which the sender holds back and the receiver stalls.
  int unsigned push_gap_pct  = 26;
  int unsigned pop_stall_pct = 62;

  ownership_ledger #(SLOTS) ledger;

  zone_ownership_mask_table #(
    .STRING_SLOTS(SLOTS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push_i),
    .full_o           (full_o),
    .kind_i           (kind_i),
    .string_index_i   (string_index_i),
    .zone_index_i     (zone_index_i),
    .zone_mask_i      (zone_mask_i),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .released_string_o(released_string_o),
    .last_of_run_o    (last_of_run_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic zone_beat_t beat(logic [KindW-1:0] kind, logic [IdxW-1:0] idx,
                                      logic [ZoneW-1:0] zone, logic [MaskW-1:0] mask);
    zone_beat_t b;
    b.kind = kind;
    b.idx  = idx;
    b.zone = zone;
    b.mask = mask;
    return b;
  endfunction

  // Random beats are steered towards a dozen low entries and a handful of low
  // zones, so that registrations pile up on the same entries and unregister and
  // release beats actually empty them. A minority use the full index, zone and
  // mask ranges so that every bit of every field is exercised.
  function automatic logic [IdxW-1:0] random_entry();
    if ($urandom_range(99) < 85) return IdxW'($urandom_range(1, 12));
    return IdxW'($urandom_range(0, 63));
  endfunction

  function automatic zone_beat_t random_beat();
    zone_beat_t  b;
    int unsigned pick;
    int unsigned sel;
    b.kind = KIND_REG;
    b.idx  = random_entry();
    b.zone = ZoneW'($urandom_range(63));
    b.mask = {$urandom, $urandom};
    pick   = $urandom_range(99);
    if (pick < 40) begin
      sel = $urandom_range(9);
      if (sel < 3)      b.zone = '0;
      else if (sel < 9) b.zone = ZoneW'($urandom_range(1, 7));
    end else if (pick < 65) begin
      b.kind = KIND_UNREG;
    end else if (pick < 90) begin
      b.kind = KIND_REL;
      sel    = $urandom_range(9);
      if (sel == 1) begin
        b.mask = '1;
      end else if (sel > 1) begin
        // A sparse mask of one or two zones, occasionally touching bit 0 too.
        b.mask = '0;
        b.mask[$urandom_range(1, 7)] = 1'b1;
        if ($urandom_range(1) == 1) b.mask[$urandom_range(0, 63)] = 1'b1;
      end
    end else begin
      // Noise: the unused kind, or an item aimed at the reserved entry 0.
      b.kind = ($urandom_range(1) == 1) ? KIND_SPARE : KindW'($urandom_range(1));
      if (b.kind != KIND_SPARE) b.idx = '0;
    end
    return b;
  endfunction

  // Offers one beat and returns at the edge that accepts it. push_i is only
  // lowered for a gap, so a run of beats keeps it high without a drop in
  // between.
  task automatic send_beat(zone_beat_t b);
    while ($urandom_range(99) < push_gap_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i         <= 1'b1;
    kind_i         <= b.kind;
    string_index_i <= b.idx;
    zone_index_i   <= b.zone;
    zone_mask_i    <= b.mask;
    do @(posedge clk_i); while (full_o);
    ledger.note_beat(b);
  endtask

  // Holds the sender back until every outstanding release has come out.
  task automatic wait_for_releases();
    push_i <= 1'b0;
    do @(posedge clk_i); while (ledger.pending() != 0);
  endtask

  // Receiver: checks each accepted result beat and redraws pop_i every cycle.
  initial begin
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (pop_i && !empty_o) ledger.check_release(released_string_o, last_of_run_o);
      pop_i <= ($urandom_range(99) >= pop_stall_pct);
      @(posedge clk_i);
    end
  end

  initial begin
    ledger = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats: reserved entry, unused kind, zero count, empty release,
    // extreme entry and zone, a single unregister release and a multi-entry
    // release whose final beat carries the last marker.
    send_beat(beat(KIND_REG,   6'd0,  6'd5,  '0));
    send_beat(beat(KIND_UNREG, 6'd0,  6'd0,  '0));
    send_beat(beat(KIND_SPARE, 6'd9,  6'd3,  '1));
    send_beat(beat(KIND_UNREG, 6'd5,  6'd0,  '0));
    send_beat(beat(KIND_REL,   6'd0,  6'd0,  64'd1));
    send_beat(beat(KIND_REG,   6'd63, 6'd63, '0));
    send_beat(beat(KIND_REG,   6'd63, 6'd0,  '0));
    // Bit 63 still owns entry 63, so dropping its zone-0 reference releases nothing.
    send_beat(beat(KIND_UNREG, 6'd63, 6'd0,  '0));
    send_beat(beat(KIND_REG,   6'd1,  6'd0,  '0));
    send_beat(beat(KIND_UNREG, 6'd1,  6'd0,  '0));
    send_beat(beat(KIND_REG,   6'd2,  6'd7,  '0));
    send_beat(beat(KIND_REG,   6'd3,  6'd7,  '0));
    send_beat(beat(KIND_REG,   6'd4,  6'd40, '0));
    send_beat(beat(KIND_REG,   6'd4,  6'd0,  '0));
    // Full mask: entries 2, 3 and 63 empty; entry 4 keeps its zone-0 bit.
    send_beat(beat(KIND_REL,   6'd0,  6'd0,  '1));
    send_beat(beat(KIND_UNREG, 6'd4,  6'd0,  '0));
    send_beat(beat(KIND_REL,   6'd0,  6'd0,  '1));
    wait_for_releases();

    // Random beats in three phases: a slow receiver, then a slow sender, then
    // both at full rate. Each phase drains completely before the next.
    for (int phase = 0; phase < 3; phase++) begin
      push_gap_pct  = (phase == 0) ? 26 : (phase == 1) ? 62 : 0;
      pop_stall_pct = (phase == 0) ? 62 : (phase == 1) ? 26 : 0;
      for (int n = 0; n < 160; n++) send_beat(random_beat());
      wait_for_releases();
    end

    // A release walks the whole table, so give any stray result beat time to show.
    repeat (3 * SLOTS) @(posedge clk_i);
    if (ledger.faults == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // About 500 beats finish well within this limit even if every beat were a
  // release of 63 entries against a stalling receiver, so it leaves ample headroom.
  initial begin
    #4ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
